[hdl/pirf_pkg.sv]
// package: widths, payload types and rounding helpers for the relative pose block
`timescale 1ns / 1ps
package pirf_pkg;

    localparam int POS_W      = 32;
    localparam int ROT_W      = 16;
    localparam int DIFF_W     = POS_W + 1;
    localparam int QPROD_W    = 2 * ROT_W;
    localparam int QSUM_W     = QPROD_W + 2;
    localparam int MATQ_W     = QPROD_W + 2;
    localparam int MAT_SHIFT  = 12;
    localparam int MAT_W      = MATQ_W - MAT_SHIFT;
    localparam int PPROD_W    = MAT_W + DIFF_W;
    localparam int PSUM_W     = PPROD_W + 2;
    localparam int POS_FRAC   = 16;
    localparam int ROT_FRAC   = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_POS_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_POS_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_POS_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROT_W = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROT_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROT_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROT_Z = 3'd6;

    localparam logic signed [ROT_W-1:0]  ROT_ONE   = 16'sd16384;
    localparam logic signed [ROT_W-1:0]  ROT_MAX   = 16'sh7fff;
    localparam logic signed [ROT_W-1:0]  ROT_MIN   = 16'sh8000;
    localparam logic signed [POS_W-1:0]  POS_MAX   = 32'sh7fffffff;
    localparam logic signed [POS_W-1:0]  POS_MIN   = 32'sh80000000;
    localparam logic signed [MATQ_W-1:0] MATQ_ONE  = 34'sd268435456;
    localparam logic signed [MATQ_W-1:0] MATQ_HALF = 34'sd2048;
    localparam logic signed [QSUM_W-1:0] QSUM_HALF = 34'sd8192;
    localparam logic signed [PSUM_W-1:0] PSUM_HALF = 57'sd32768;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [ROT_W-1:0] rot_w;
        logic signed [ROT_W-1:0] rot_x;
        logic signed [ROT_W-1:0] rot_y;
        logic signed [ROT_W-1:0] rot_z;
    } t_pose_in;

    typedef struct packed {
        logic signed [POS_W-1:0] rel_pos_x;
        logic signed [POS_W-1:0] rel_pos_y;
        logic signed [POS_W-1:0] rel_pos_z;
        logic signed [ROT_W-1:0] rel_rot_w;
        logic signed [ROT_W-1:0] rel_rot_x;
        logic signed [ROT_W-1:0] rel_rot_y;
        logic signed [ROT_W-1:0] rel_rot_z;
    } t_pose_out;

    typedef struct packed {
        logic signed [ROT_W-1:0] w;
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic signed [ROT_W-1:0] z;
    } t_quat;

    typedef struct packed {
        logic signed [MAT_W-1:0] r00;
        logic signed [MAT_W-1:0] r01;
        logic signed [MAT_W-1:0] r02;
        logic signed [MAT_W-1:0] r10;
        logic signed [MAT_W-1:0] r11;
        logic signed [MAT_W-1:0] r12;
        logic signed [MAT_W-1:0] r20;
        logic signed [MAT_W-1:0] r21;
        logic signed [MAT_W-1:0] r22;
    } t_rotmat;

    function automatic logic signed [MAT_W-1:0] round_mat(input logic signed [MATQ_W-1:0] v);
        logic signed [MATQ_W-1:0] t;
        t = v + MATQ_HALF;
        return t[MATQ_W-1:MAT_SHIFT];
    endfunction

    function automatic logic signed [ROT_W-1:0] round_sat_rot(
        input logic signed [QSUM_W-1:0] v
    );
        logic signed [QSUM_W-1:0] t;
        t = v + QSUM_HALF;
        if ((&t[QSUM_W-1:ROT_FRAC+ROT_W-1]) || !(|t[QSUM_W-1:ROT_FRAC+ROT_W-1])) begin
            return t[ROT_FRAC+ROT_W-1:ROT_FRAC];
        end else begin
            return t[QSUM_W-1] ? ROT_MIN : ROT_MAX;
        end
    endfunction

    function automatic logic signed [POS_W-1:0] round_sat_pos(
        input logic signed [PSUM_W-1:0] v
    );
        logic signed [PSUM_W-1:0] t;
        t = v + PSUM_HALF;
        if ((&t[PSUM_W-1:POS_FRAC+POS_W-1]) || !(|t[PSUM_W-1:POS_FRAC+POS_W-1])) begin
            return t[POS_FRAC+POS_W-1:POS_FRAC];
        end else begin
            return t[PSUM_W-1] ? POS_MIN : POS_MAX;
        end
    endfunction

endpackage

[hdl/pirf_if.sv]
// interfaces: pose input channel, relative pose output channel, configuration write channel
`timescale 1ns / 1ps
interface pirf_in_if;
    import pirf_pkg::*;
    logic     valid;
    logic     ready;
    t_pose_in data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pirf_out_if;
    import pirf_pkg::*;
    logic      valid;
    logic      ready;
    t_pose_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pirf_cfg_if;
    import pirf_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/pose_into_reference_frame.sv]
// top level: relative pose of an object in a configured reference frame
`timescale 1ns / 1ps
// Takes one pose per cycle while i_in.ready is high and returns its relative pose
// from the output register; up to three poses are in flight. The pipeline has three
// register stages: position difference and the sixteen quaternion products, then
// the nine 22x33 matrix-by-difference multiplies and the quaternion sums, then the
// position accumulate with rounding and saturation into the output register.
// Each stage holds its item while the next one is full, so bubbles close up and
// the input keeps taking poses while a result waits at the output, until every
// stage is full. The rotation matrix is rebuilt from the frame quaternion by a
// two-stage unit; after reset and after every configuration write the input holds
// ready low while that matrix settles. Configuration writes are always taken and
// must only be issued while no pose is in flight; an index above six is ignored.
module pose_into_reference_frame (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pirf_in_if.sink           i_in,
    pirf_out_if.source        o_out,
    pirf_cfg_if.sink          i_cfg
);
    import pirf_pkg::*;

    logic signed [POS_W-1:0]   r_fpos_x, r_fpos_y, r_fpos_z;
    t_quat                     r_frot;
    logic [1:0]                r_busy;
    t_rotmat                   w_mat;

    logic                      w_in_xfer, w_cfg_xfer;
    logic                      w_en1, w_en2, w_en3;

    logic                      r_v1, r_v2, r_v3;
    logic signed [DIFF_W-1:0]  r_d_x, r_d_y, r_d_z;
    logic signed [QPROD_W-1:0] r_qp [4][4];
    logic signed [ROT_W-1:0]   w_qin [4];
    logic signed [ROT_W-1:0]   w_qfr [4];

    logic signed [PPROD_W-1:0] r_pp [3][3];
    t_quat                     r_q2;
    t_pose_out                 r_out;

    assign w_cfg_xfer = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;

    // frame registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fpos_x <= '0;
            r_fpos_y <= '0;
            r_fpos_z <= '0;
            r_frot.w <= ROT_ONE;
            r_frot.x <= '0;
            r_frot.y <= '0;
            r_frot.z <= '0;
        end else if (w_cfg_xfer) begin
            case (i_cfg.index)
                CFG_FRAME_POS_X: r_fpos_x <= i_cfg.data;
                CFG_FRAME_POS_Y: r_fpos_y <= i_cfg.data;
                CFG_FRAME_POS_Z: r_fpos_z <= i_cfg.data;
                CFG_FRAME_ROT_W: r_frot.w <= i_cfg.data[ROT_W-1:0];
                CFG_FRAME_ROT_X: r_frot.x <= i_cfg.data[ROT_W-1:0];
                CFG_FRAME_ROT_Y: r_frot.y <= i_cfg.data[ROT_W-1:0];
                CFG_FRAME_ROT_Z: r_frot.z <= i_cfg.data[ROT_W-1:0];
                default: ;
            endcase
        end
    end

    // matrix settle hold-off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 2'd2;
        end else if (w_cfg_xfer) begin
            r_busy <= 2'd2;
        end else if (r_busy != 2'd0) begin
            r_busy <= r_busy - 2'd1;
        end
    end

    pirf_rotmat u_rotmat (
        .i_clk (i_clk),
        .i_rot (r_frot),
        .o_mat (w_mat)
    );

    // stage enables
    assign w_en3 = !r_v3 || o_out.ready;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign i_in.ready = w_en1 && (r_busy == 2'd0);
    assign w_in_xfer = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= w_in_xfer;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_comb begin
        w_qin[0] = i_in.data.rot_w;
        w_qin[1] = i_in.data.rot_x;
        w_qin[2] = i_in.data.rot_y;
        w_qin[3] = i_in.data.rot_z;
        w_qfr[0] = r_frot.w;
        w_qfr[1] = r_frot.x;
        w_qfr[2] = r_frot.y;
        w_qfr[3] = r_frot.z;
    end

    // stage 1: difference and quaternion products
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_d_x <= DIFF_W'(i_in.data.pos_x) - DIFF_W'(r_fpos_x);
            r_d_y <= DIFF_W'(i_in.data.pos_y) - DIFF_W'(r_fpos_y);
            r_d_z <= DIFF_W'(i_in.data.pos_z) - DIFF_W'(r_fpos_z);
            for (int a = 0; a < 4; a++) begin
                for (int b = 0; b < 4; b++) begin
                    r_qp[a][b] <= w_qin[a] * w_qfr[b];
                end
            end
        end
    end

    // stage 2: transposed matrix times difference, quaternion sums
    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_pp[0][0] <= w_mat.r00 * r_d_x;
            r_pp[0][1] <= w_mat.r10 * r_d_y;
            r_pp[0][2] <= w_mat.r20 * r_d_z;
            r_pp[1][0] <= w_mat.r01 * r_d_x;
            r_pp[1][1] <= w_mat.r11 * r_d_y;
            r_pp[1][2] <= w_mat.r21 * r_d_z;
            r_pp[2][0] <= w_mat.r02 * r_d_x;
            r_pp[2][1] <= w_mat.r12 * r_d_y;
            r_pp[2][2] <= w_mat.r22 * r_d_z;
            r_q2.w <= round_sat_rot(QSUM_W'(r_qp[0][0]) + QSUM_W'(r_qp[1][1])
                                  + QSUM_W'(r_qp[2][2]) + QSUM_W'(r_qp[3][3]));
            r_q2.x <= round_sat_rot(QSUM_W'(r_qp[1][0]) - QSUM_W'(r_qp[0][1])
                                  - QSUM_W'(r_qp[2][3]) + QSUM_W'(r_qp[3][2]));
            r_q2.y <= round_sat_rot(QSUM_W'(r_qp[1][3]) - QSUM_W'(r_qp[0][2])
                                  + QSUM_W'(r_qp[2][0]) - QSUM_W'(r_qp[3][1]));
            r_q2.z <= round_sat_rot(QSUM_W'(r_qp[2][1]) - QSUM_W'(r_qp[0][3])
                                  - QSUM_W'(r_qp[1][2]) + QSUM_W'(r_qp[3][0]));
        end
    end

    // stage 3: accumulate, round, saturate into the output register
    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_out.rel_pos_x <= round_sat_pos(PSUM_W'(r_pp[0][0]) + PSUM_W'(r_pp[0][1])
                                           + PSUM_W'(r_pp[0][2]));
            r_out.rel_pos_y <= round_sat_pos(PSUM_W'(r_pp[1][0]) + PSUM_W'(r_pp[1][1])
                                           + PSUM_W'(r_pp[1][2]));
            r_out.rel_pos_z <= round_sat_pos(PSUM_W'(r_pp[2][0]) + PSUM_W'(r_pp[2][1])
                                           + PSUM_W'(r_pp[2][2]));
            r_out.rel_rot_w <= r_q2.w;
            r_out.rel_rot_x <= r_q2.x;
            r_out.rel_rot_y <= r_q2.y;
            r_out.rel_rot_z <= r_q2.z;
        end
    end

    assign o_out.valid = r_v3;
    assign o_out.data  = r_out;

    // no pose enters while the matrix is being rebuilt
    a_cfg_holdoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_xfer |=> !i_in.ready)
        else $error("pose transfer allowed right after a frame write");

    // a stalled middle stage keeps its item
    a_stage2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !w_en3 |=> r_v2)
        else $error("stage 2 item dropped during stall");

    // an item that may advance reaches the next stage
    a_stage1_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && w_en2 |=> r_v2)
        else $error("stage 1 item lost on advance");

endmodule

[hdl/pirf_rotmat.sv]
// rotation matrix of the frame quaternion, two register stages, rounded to q.16
`timescale 1ns / 1ps
module pirf_rotmat (
    input  logic             i_clk,
    input  pirf_pkg::t_quat   i_rot,
    output pirf_pkg::t_rotmat o_mat
);
    import pirf_pkg::*;

    logic signed [QPROD_W-1:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    t_rotmat                   r_mat;
    t_rotmat                   n_mat;

    always_ff @(posedge i_clk) begin
        r_xx <= i_rot.x * i_rot.x;
        r_yy <= i_rot.y * i_rot.y;
        r_zz <= i_rot.z * i_rot.z;
        r_xy <= i_rot.x * i_rot.y;
        r_xz <= i_rot.x * i_rot.z;
        r_yz <= i_rot.y * i_rot.z;
        r_wx <= i_rot.w * i_rot.x;
        r_wy <= i_rot.w * i_rot.y;
        r_wz <= i_rot.w * i_rot.z;
    end

    always_comb begin
        n_mat.r00 = round_mat(MATQ_ONE - ((MATQ_W'(r_yy) + MATQ_W'(r_zz)) <<< 1));
        n_mat.r01 = round_mat((MATQ_W'(r_xy) - MATQ_W'(r_wz)) <<< 1);
        n_mat.r02 = round_mat((MATQ_W'(r_xz) + MATQ_W'(r_wy)) <<< 1);
        n_mat.r10 = round_mat((MATQ_W'(r_xy) + MATQ_W'(r_wz)) <<< 1);
        n_mat.r11 = round_mat(MATQ_ONE - ((MATQ_W'(r_xx) + MATQ_W'(r_zz)) <<< 1));
        n_mat.r12 = round_mat((MATQ_W'(r_yz) - MATQ_W'(r_wx)) <<< 1);
        n_mat.r20 = round_mat((MATQ_W'(r_xz) - MATQ_W'(r_wy)) <<< 1);
        n_mat.r21 = round_mat((MATQ_W'(r_yz) + MATQ_W'(r_wx)) <<< 1);
        n_mat.r22 = round_mat(MATQ_ONE - ((MATQ_W'(r_xx) + MATQ_W'(r_yy)) <<< 1));
    end

    always_ff @(posedge i_clk) begin
        r_mat <= n_mat;
    end

    assign o_mat = r_mat;

endmodule

[dv/tb_pose_into_reference_frame.sv]
// testbench: random and directed poses checked against a fixed-point relative pose predictor
`timescale 1ns / 1ps
module tb_pose_into_reference_frame;
    import pirf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam longint MAT_ONE_Q28 = 64'sd268435456;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASES = 10;
    localparam int PHASE_POSES = 113;

    logic i_clk;
    logic i_rst_n;

    pirf_in_if  pose_in ();
    pirf_out_if pose_out ();
    pirf_cfg_if frame_cfg ();

    pose_into_reference_frame DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (pose_in),
        .o_out   (pose_out),
        .i_cfg   (frame_cfg)
    );

    longint    frame_pos [3];
    longint    frame_rot [4];
    t_pose_in  pose_q [$];
    t_pose_out rel_pose_due_q [$];
    int        mismatch_cnt = 0;
    int        src_gap_pct = 0;
    int        sink_stall_pct = 0;
    int        gap_left = 0;
    int        stall_left = 0;
    logic      hold_go = 1'b0;
    logic      sink_hold;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint round_shr(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_to(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) << (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic t_pose_out predict_rel_pose(input t_pose_in p);
        longint fw, fx, fy, fz, w, x, y, z, acc;
        longint d [3];
        longint m [3][3];
        longint rp [3];
        longint rq [4];
        t_pose_out r;
        fw = frame_rot[0];
        fx = frame_rot[1];
        fy = frame_rot[2];
        fz = frame_rot[3];
        d[0] = longint'($signed(p.pos_x)) - frame_pos[0];
        d[1] = longint'($signed(p.pos_y)) - frame_pos[1];
        d[2] = longint'($signed(p.pos_z)) - frame_pos[2];
        m[0][0] = MAT_ONE_Q28 - 2 * (fy * fy + fz * fz);
        m[0][1] = 2 * (fx * fy - fw * fz);
        m[0][2] = 2 * (fx * fz + fw * fy);
        m[1][0] = 2 * (fx * fy + fw * fz);
        m[1][1] = MAT_ONE_Q28 - 2 * (fx * fx + fz * fz);
        m[1][2] = 2 * (fy * fz - fw * fx);
        m[2][0] = 2 * (fx * fz - fw * fy);
        m[2][1] = 2 * (fy * fz + fw * fx);
        m[2][2] = MAT_ONE_Q28 - 2 * (fx * fx + fy * fy);
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                m[i][k] = round_shr(m[i][k], MAT_SHIFT);
        // transposed matrix times the position difference
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int k = 0; k < 3; k++)
                acc += m[k][i] * d[k];
            rp[i] = clamp_to(round_shr(acc, POS_FRAC), POS_W);
        end
        w = longint'($signed(p.rot_w));
        x = longint'($signed(p.rot_x));
        y = longint'($signed(p.rot_y));
        z = longint'($signed(p.rot_z));
        // object quaternion times frame conjugate
        rq[0] = w * fw + x * fx + y * fy + z * fz;
        rq[1] = -w * fx + x * fw - y * fz + z * fy;
        rq[2] = -w * fy + x * fz + y * fw - z * fx;
        rq[3] = -w * fz - x * fy + y * fx + z * fw;
        for (int i = 0; i < 4; i++)
            rq[i] = clamp_to(round_shr(rq[i], ROT_FRAC), ROT_W);
        r.rel_pos_x = rp[0][POS_W-1:0];
        r.rel_pos_y = rp[1][POS_W-1:0];
        r.rel_pos_z = rp[2][POS_W-1:0];
        r.rel_rot_w = rq[0][ROT_W-1:0];
        r.rel_rot_x = rq[1][ROT_W-1:0];
        r.rel_rot_y = rq[2][ROT_W-1:0];
        r.rel_rot_z = rq[3][ROT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_cnt++;
        if (mismatch_cnt <= 40)
            $display("%0t: %s mismatch: got %0d want %0d", $realtime, what, got, want);
    endtask

    task automatic check_rel_pose(input t_pose_out got, input t_pose_out want);
        if (got.rel_pos_x !== want.rel_pos_x)
            report_mismatch("rel_pos_x", $signed(got.rel_pos_x), $signed(want.rel_pos_x));
        if (got.rel_pos_y !== want.rel_pos_y)
            report_mismatch("rel_pos_y", $signed(got.rel_pos_y), $signed(want.rel_pos_y));
        if (got.rel_pos_z !== want.rel_pos_z)
            report_mismatch("rel_pos_z", $signed(got.rel_pos_z), $signed(want.rel_pos_z));
        if (got.rel_rot_w !== want.rel_rot_w)
            report_mismatch("rel_rot_w", $signed(got.rel_rot_w), $signed(want.rel_rot_w));
        if (got.rel_rot_x !== want.rel_rot_x)
            report_mismatch("rel_rot_x", $signed(got.rel_rot_x), $signed(want.rel_rot_x));
        if (got.rel_rot_y !== want.rel_rot_y)
            report_mismatch("rel_rot_y", $signed(got.rel_rot_y), $signed(want.rel_rot_y));
        if (got.rel_rot_z !== want.rel_rot_z)
            report_mismatch("rel_rot_z", $signed(got.rel_rot_z), $signed(want.rel_rot_z));
    endtask

    function automatic int pick_gap(input int pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [POS_W-1:0] extreme_coord();
        case ($urandom_range(0, 4))
            0: return POS_MIN;
            1: return POS_MAX;
            2: return '0;
            3: return '1;
            default: return 32'd1;
        endcase
    endfunction

    function automatic logic [ROT_W-1:0] extreme_rot();
        case ($urandom_range(0, 4))
            0: return ROT_MIN;
            1: return ROT_MAX;
            2: return '0;
            3: return ROT_ONE;
            default: return -ROT_ONE;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] random_coord();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) return $urandom;
        if (sel < 9) return POS_W'(int'($urandom_range(0, 33554431)) - 16777216);
        return extreme_coord();
    endfunction

    function automatic t_quat random_unit_quat();
        real a [4];
        real n;
        t_quat q;
        n = 0.0;
        while (n < 0.05) begin
            for (int i = 0; i < 4; i++)
                a[i] = (real'(int'($urandom_range(0, 20000))) - 10000.0) / 10000.0;
            n = $sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2] + a[3] * a[3]);
        end
        q.w = ROT_W'($rtoi(a[0] / n * 16384.0));
        q.x = ROT_W'($rtoi(a[1] / n * 16384.0));
        q.y = ROT_W'($rtoi(a[2] / n * 16384.0));
        q.z = ROT_W'($rtoi(a[3] / n * 16384.0));
        return q;
    endfunction

    function automatic t_quat random_quat();
        int sel;
        t_quat q;
        sel = $urandom_range(0, 9);
        if (sel < 6) return random_unit_quat();
        if (sel < 9) begin
            q.w = ROT_W'($urandom);
            q.x = ROT_W'($urandom);
            q.y = ROT_W'($urandom);
            q.z = ROT_W'($urandom);
        end else begin
            q.w = extreme_rot();
            q.x = extreme_rot();
            q.y = extreme_rot();
            q.z = extreme_rot();
        end
        return q;
    endfunction

    function automatic t_pose_in make_pose(input logic [POS_W-1:0] px, py, pz,
                                           input logic [ROT_W-1:0] rw, rx, ry, rz);
        t_pose_in p;
        p.pos_x = px;
        p.pos_y = py;
        p.pos_z = pz;
        p.rot_w = rw;
        p.rot_x = rx;
        p.rot_y = ry;
        p.rot_z = rz;
        return p;
    endfunction

    function automatic t_pose_in random_pose();
        t_quat q;
        q = random_quat();
        return make_pose(random_coord(), random_coord(), random_coord(), q.w, q.x, q.y, q.z);
    endfunction

    task automatic write_frame_reg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        frame_cfg.valid <= 1'b1;
        frame_cfg.index <= idx;
        frame_cfg.data  <= value;
        do @(posedge i_clk); while (!frame_cfg.ready);
        case (idx)
            CFG_FRAME_POS_X, CFG_FRAME_POS_Y, CFG_FRAME_POS_Z:
                frame_pos[idx[1:0]] = longint'($signed(value));
            CFG_FRAME_ROT_W, CFG_FRAME_ROT_X, CFG_FRAME_ROT_Y, CFG_FRAME_ROT_Z:
                frame_rot[2'(idx - CFG_FRAME_ROT_W)] = longint'($signed(value[ROT_W-1:0]));
            default: ;
        endcase
        frame_cfg.valid <= 1'b0;
    endtask

    task automatic load_frame(input logic [POS_W-1:0] px, py, pz, input t_quat q);
        write_frame_reg(CFG_FRAME_POS_X, px);
        write_frame_reg(CFG_FRAME_POS_Y, py);
        write_frame_reg(CFG_FRAME_POS_Z, pz);
        // upper bits of the rotation registers are don't care
        write_frame_reg(CFG_FRAME_ROT_W, {16'($urandom), q.w});
        write_frame_reg(CFG_FRAME_ROT_X, {16'($urandom), q.x});
        write_frame_reg(CFG_FRAME_ROT_Y, {16'($urandom), q.y});
        write_frame_reg(CFG_FRAME_ROT_Z, {16'($urandom), q.z});
    endtask

    task automatic wait_drained();
        while (pose_q.size() != 0 || pose_in.valid || rel_pose_due_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic push_directed_poses();
        pose_q.push_back(make_pose('0, '0, '0, ROT_ONE, '0, '0, '0));
        pose_q.push_back(make_pose(POS_MAX, POS_MAX, POS_MAX, ROT_MAX, ROT_MAX, ROT_MAX,
                                   ROT_MAX));
        pose_q.push_back(make_pose(POS_MIN, POS_MIN, POS_MIN, ROT_MIN, ROT_MIN, ROT_MIN,
                                   ROT_MIN));
        pose_q.push_back(make_pose(POS_MAX, POS_MIN, '0, ROT_ONE, '0, '0, '0));
        pose_q.push_back(make_pose(POS_MIN, POS_MAX, 32'd1, '0, ROT_MIN, ROT_MAX, '0));
        pose_q.push_back(make_pose('1, '1, '1, '1, '1, '1, '1));
        pose_q.push_back(make_pose(32'h0001_0000, 32'hffff_0000, 32'h0000_8000, '0, '0, '0,
                                   ROT_ONE));
        pose_q.push_back(make_pose(POS_MAX, POS_MAX, POS_MIN, ROT_MIN, ROT_MAX, ROT_MIN,
                                   ROT_MAX));
    endtask

    // pose driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pose_in.valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (pose_in.valid && pose_in.ready)
                rel_pose_due_q.push_back(predict_rel_pose(pose_in.data));
            if (!pose_in.valid || pose_in.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    pose_in.valid <= 1'b0;
                end else if (pose_q.size() != 0) begin
                    pose_in.data  <= pose_q.pop_front();
                    pose_in.valid <= 1'b1;
                    gap_left = pick_gap(src_gap_pct);
                end else begin
                    pose_in.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pose_out.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (pose_out.valid && pose_out.ready) begin
                if (rel_pose_due_q.size() == 0)
                    report_mismatch("unexpected transfer", $signed(pose_out.data.rel_pos_x), 0);
                else
                    check_rel_pose(pose_out.data, rel_pose_due_q.pop_front());
            end
            if (sink_hold) begin
                pose_out.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                pose_out.ready <= 1'b0;
            end else begin
                stall_left = pick_gap(sink_stall_pct);
                if (stall_left > 0) begin
                    stall_left--;
                    pose_out.ready <= 1'b0;
                end else begin
                    pose_out.ready <= 1'b1;
                end
            end
        end
    end

    // long output hold-off while the sender keeps offering
    initial begin
        sink_hold = 1'b0;
        wait (hold_go);
        @(posedge i_clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        sink_hold <= 1'b0;
    end

    initial begin : stimulus
        t_quat q;
        int    mode;
        i_rst_n = 1'b0;
        pose_in.valid = 1'b0;
        pose_in.data = '0;
        pose_out.ready = 1'b0;
        frame_cfg.valid = 1'b0;
        frame_cfg.index = '0;
        frame_cfg.data = '0;
        frame_pos = '{0, 0, 0};
        frame_rot = '{16384, 0, 0, 0};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset frame: identity at the origin
        push_directed_poses();
        wait_drained();

        // extreme frame: saturating positions and a non-unit quaternion
        q.w = ROT_MIN;
        q.x = ROT_MAX;
        q.y = ROT_MAX;
        q.z = ROT_MAX;
        load_frame(POS_MAX, POS_MIN, '0, q);
        write_frame_reg(CFG_UNUSED, $urandom);
        push_directed_poses();
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            mode = (ph == 0) ? 2 : $urandom_range(0, 3);
            case (mode)
                0: load_frame(random_coord(), random_coord(), random_coord(),
                              random_unit_quat());
                1: begin
                    q.w = ROT_W'($urandom);
                    q.x = ROT_W'($urandom);
                    q.y = ROT_W'($urandom);
                    q.z = ROT_W'($urandom);
                    load_frame($urandom, $urandom, $urandom, q);
                end
                2: begin
                    q.w = extreme_rot();
                    q.x = extreme_rot();
                    q.y = extreme_rot();
                    q.z = extreme_rot();
                    load_frame(extreme_coord(), extreme_coord(), extreme_coord(), q);
                end
                default: begin
                    q.w = ROT_ONE;
                    q.x = '0;
                    q.y = '0;
                    q.z = '0;
                    load_frame(random_coord(), random_coord(), random_coord(), q);
                end
            endcase
            if ($urandom_range(0, 2) == 0)
                write_frame_reg(CFG_UNUSED, $urandom);
            src_gap_pct    = (ph % 3 == 0) ? 0 : $urandom_range(10, 50);
            sink_stall_pct = (ph % 3 == 0) ? 0 : $urandom_range(10, 50);
            if (ph == 2) begin
                src_gap_pct = 0;
                hold_go = 1'b1;
            end
            for (int n = 0; n < PHASE_POSES; n++)
                pose_q.push_back(random_pose());
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (mismatch_cnt == 0 && rel_pose_due_q.size() == 0) begin
            $display("pose_into_reference_frame test passed");
        end else begin
            $display("pose_into_reference_frame test failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("pose_into_reference_frame test failed");
        $finish;
    end

endmodule
